// ===== rtl/pngsd_pkg.sv =====
`default_nettype none
package pngsd_pkg;

  localparam int DIM_W = 14;
  localparam int COL_W = 13;
  localparam int PIX_W = 27;
  localparam int RAW_W = 28;
  localparam int IDX_W = 6;

  // Configuration register indexes.
  localparam logic CFG_WIDTH  = 1'b0;
  localparam logic CFG_HEIGHT = 1'b1;

  // Input function codes.
  localparam logic FUNC_START = 1'b0;
  localparam logic FUNC_PIXEL = 1'b1;

  localparam logic [IDX_W-1:0] MAX_OUT = 6'd43;

  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [16:0] ADLER_MOD = 17'd65521;

  localparam logic [0:7][7:0] PNG_SIG =
    {8'h89, 8'h50, 8'h4E, 8'h47, 8'h0D, 8'h0A, 8'h1A, 8'h0A};
  localparam logic [0:3][7:0] IHDR_TYPE = {8'h49, 8'h48, 8'h44, 8'h52};
  localparam logic [0:3][7:0] IDAT_TYPE = {8'h49, 8'h44, 8'h41, 8'h54};
  localparam logic [0:11][7:0] IEND_CHUNK =
    {8'h00, 8'h00, 8'h00, 8'h00, 8'h49, 8'h45, 8'h4E, 8'h44,
     8'hAE, 8'h42, 8'h60, 8'h82};
  localparam logic [7:0] IHDR_LEN  = 8'h0D;
  localparam logic [7:0] BIT_DEPTH = 8'h08;
  localparam logic [7:0] COLOR_RGB = 8'h02;
  localparam logic [7:0] ZLIB_CMF  = 8'h78;
  localparam logic [7:0] ZLIB_FLG  = 8'hDA;

  // Byte indexes of start sequence, block header and trailer.
  localparam logic [IDX_W-1:0] IDX_IHDR_CRC   = 6'd29;
  localparam logic [IDX_W-1:0] IDX_IDAT_LEN   = 6'd33;
  localparam logic [IDX_W-1:0] IDX_IDAT_TYPE  = 6'd37;
  localparam logic [IDX_W-1:0] IDX_START_LAST = 6'd42;
  localparam logic [IDX_W-1:0] IDX_IHDR_BODY  = 6'd12;
  localparam logic [IDX_W-1:0] IDX_BLK_LAST   = 6'd4;
  localparam logic [IDX_W-1:0] IDX_TAIL_LAST  = 6'd19;

  typedef struct packed {
    logic       func;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
    logic       end_of_file;
  } out_item_t;

  typedef struct packed {
    logic             is_start;
    logic [7:0]       red;
    logic [7:0]       green;
    logic [7:0]       blue;
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
  } cmd_t;

  typedef enum logic [1:0] {
    M_ITEM,
    M_START,
    M_BLK,
    M_TAIL
  } back_mode_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] x;
    x = c ^ {24'b0, b};
    for (int k = 0; k < 8; k++) begin
      x = x[0] ? (CRC_POLY ^ (x >> 1)) : (x >> 1);
    end
    return x;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/pngsd_front.sv =====
`default_nettype none
module pngsd_front import pngsd_pkg::*; #(
  parameter int MAX_DIMENSION = 8192
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_we,
  input  wire logic             cfg_addr,
  input  wire logic [DIM_W-1:0] cfg_wdata,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire in_item_t         in_data,
  input  wire logic             q_full,
  output logic                  q_push,
  output cmd_t                  q_cmd
);

  localparam logic [DIM_W-1:0] MAX_DIM = DIM_W'(MAX_DIMENSION);

  logic [DIM_W-1:0] width_r, height_r;
  logic [DIM_W-1:0] cw, ch;
  logic             open_r, open_nxt;
  logic [PIX_W-1:0] pix_left_r, pix_left_nxt;
  logic [2*DIM_W-1:0] area;
  logic             accept;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    if (v == '0) return DIM_W'(1);
    if (v > MAX_DIM) return MAX_DIM;
    return v;
  endfunction

  assign cw       = clamp_dim(width_r);
  assign ch       = clamp_dim(height_r);
  assign area     = cw * ch;
  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    open_nxt     = open_r;
    pix_left_nxt = pix_left_r;
    q_push       = 1'b0;
    q_cmd.is_start = (in_data.func == FUNC_START);
    q_cmd.red      = in_data.red;
    q_cmd.green    = in_data.green;
    q_cmd.blue     = in_data.blue;
    q_cmd.width    = cw;
    q_cmd.height   = ch;
    if (accept) begin
      if (in_data.func == FUNC_START) begin
        q_push       = 1'b1;
        open_nxt     = 1'b1;
        pix_left_nxt = area[PIX_W-1:0];
      end else if (open_r) begin
        // Only pixels inside the open image are pushed.
        q_push       = 1'b1;
        pix_left_nxt = pix_left_r - PIX_W'(1);
        if (pix_left_r == PIX_W'(1)) open_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r    <= DIM_W'(1);
      height_r   <= DIM_W'(1);
      open_r     <= 1'b0;
      pix_left_r <= '0;
    end else begin
      open_r     <= open_nxt;
      pix_left_r <= pix_left_nxt;
      if (cfg_we && cfg_addr == CFG_WIDTH) width_r <= cfg_wdata;
      if (cfg_we && cfg_addr == CFG_HEIGHT) height_r <= cfg_wdata;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/pngsd_fifo.sv =====
`default_nettype none
module pngsd_fifo import pngsd_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire cmd_t push_cmd,
  input  wire logic pop,
  output logic      full,
  output logic      head_valid,
  output cmd_t      head
);

  cmd_t       mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r;

  assign full       = (count_r == 2'd2);
  assign head_valid = (count_r != 2'd0);
  assign head       = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop) rd_ptr_r <= !rd_ptr_r;
      if (push && !pop) count_r <= count_r + 2'd1;
      else if (pop && !push) count_r <= count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_cmd;
  end

endmodule
`default_nettype wire

// ===== rtl/pngsd_div.sv =====
`default_nettype none
module pngsd_div import pngsd_pkg::*; #(
  parameter int BLOCK_LIMIT = 32768
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             go,
  input  wire logic [RAW_W-1:0] raw,
  output logic                  done,
  output logic [31:0]           idat_len
);

  // The block count is ceil(raw / (BLOCK_LIMIT - 5)). It is taken as a
  // reciprocal multiplication of raw + divisor - 1, with the reciprocal rounded
  // up and enough fraction bits that the quotient is exact for every 29-bit
  // value. Three registered stages: operand, product, total.
  localparam int unsigned      DIVISOR = BLOCK_LIMIT - 5;
  localparam int               NUM_W   = RAW_W + 1;
  localparam int               REC_W   = NUM_W + 1;
  localparam int               SHIFT   = NUM_W + $clog2(DIVISOR);
  localparam logic [63:0]      RECIP64 =
    ((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
  localparam logic [REC_W-1:0] RECIP   = RECIP64[REC_W-1:0];

  logic                   v1_r, v2_r, done_r;
  logic [NUM_W-1:0]       num_r;
  logic [RAW_W-1:0]       raw_r;
  logic [NUM_W+REC_W-1:0] prod_r;
  logic [RAW_W-1:0]       blocks;
  logic [31:0]            total_r;

  assign blocks   = RAW_W'(prod_r >> SHIFT);
  assign done     = done_r;
  assign idat_len = total_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      done_r <= 1'b0;
    end else begin
      v1_r <= go;
      v2_r <= v1_r;
      if (go) done_r <= 1'b0;
      else if (v2_r) done_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      num_r <= NUM_W'(raw) + NUM_W'(DIVISOR - 1);
      raw_r <= raw;
    end
    if (v1_r) prod_r <= num_r * RECIP;
    if (v2_r) begin
      // Length = zlib header + raw + five bytes per block + Adler.
      total_r <= {4'b0, raw_r} + {2'b0, blocks, 2'b0} + {4'b0, blocks} + 32'd6;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/pngsd_back.sv =====
`default_nettype none
module pngsd_back import pngsd_pkg::*; #(
  parameter int BLOCK_LIMIT = 32768
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic head_valid,
  input  wire cmd_t head,
  output logic      pop,
  output logic      out_valid,
  input  wire logic out_ready,
  output out_item_t out_data
);

  localparam logic [RAW_W-1:0] BLK_LEN = RAW_W'(BLOCK_LIMIT - 5);

  back_mode_t       mode_r, mode_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt, cnt_r, cnt_nxt;
  logic [1:0]       slot_r, slot_nxt, slot_eff;
  logic [COL_W-1:0] col_r, col_nxt;
  logic [15:0]      fill_r, fill_nxt;
  logic [RAW_W-1:0] left_r, left_nxt;
  logic [31:0]      crc_r, crc_nxt;
  logic [15:0]      adl_r, adl_nxt, adh_r, adh_nxt;
  logic [DIM_W-1:0] lw_r, lw_nxt, lh_r, lh_nxt;
  logic             mul_go_r, mul_go_nxt, div_go_r;
  logic             out_valid_r;
  out_item_t        out_data_r;

  logic             go, drop, can, crc_upd, crc_fresh, last_v, eof_v;
  logic [7:0]       byte_v, raw_b, start_b;
  logic [15:0]      len, nlen;
  logic             final_blk;
  logic [16:0]      sum_l, sum_h;
  logic [15:0]      new_l, new_h;
  logic [29:0]      raw_prod;
  logic [31:0]      crc_out, adler_word;
  logic             div_done;
  logic [31:0]      idat_len;

  pngsd_div #(.BLOCK_LIMIT(BLOCK_LIMIT)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (div_go_r),
    .raw      (left_r),
    .done     (div_done),
    .idat_len (idat_len)
  );

  assign drop       = (cnt_r == MAX_OUT);
  assign can        = drop || !out_valid_r || out_ready;
  assign slot_eff   = (slot_r == 2'd0 && col_r != '0) ? 2'd1 : slot_r;
  assign final_blk  = (left_r <= BLK_LEN);
  assign len        = (left_r < BLK_LEN) ? left_r[15:0] : BLK_LEN[15:0];
  assign nlen       = ~len;
  assign raw_prod   = lh_r * ({1'b0, lw_r, 1'b0} + {2'b0, lw_r} + 16'd1);
  assign crc_out    = ~crc_r;
  assign adler_word = {adh_r, adl_r};

  always_comb begin
    case (slot_eff)
      2'd0:    raw_b = 8'h00;
      2'd1:    raw_b = head.red;
      2'd2:    raw_b = head.green;
      default: raw_b = head.blue;
    endcase
  end

  always_comb begin
    sum_l = {1'b0, adl_r} + {9'b0, raw_b};
    new_l = (sum_l >= ADLER_MOD) ? 16'(sum_l - ADLER_MOD) : sum_l[15:0];
    sum_h = {1'b0, adh_r} + {1'b0, new_l};
    new_h = (sum_h >= ADLER_MOD) ? 16'(sum_h - ADLER_MOD) : sum_h[15:0];
  end

  always_comb begin
    case (idx_r) inside
      [6'd0:6'd7]:   start_b = PNG_SIG[idx_r[2:0]];
      6'd11:         start_b = IHDR_LEN;
      [6'd12:6'd15]: start_b = IHDR_TYPE[idx_r[1:0]];
      6'd18:         start_b = {2'b0, lw_r[13:8]};
      6'd19:         start_b = lw_r[7:0];
      6'd22:         start_b = {2'b0, lh_r[13:8]};
      6'd23:         start_b = lh_r[7:0];
      6'd24:         start_b = BIT_DEPTH;
      6'd25:         start_b = COLOR_RGB;
      6'd29:         start_b = crc_out[31:24];
      6'd30:         start_b = crc_out[23:16];
      6'd31:         start_b = crc_out[15:8];
      6'd32:         start_b = crc_out[7:0];
      6'd33:         start_b = idat_len[31:24];
      6'd34:         start_b = idat_len[23:16];
      6'd35:         start_b = idat_len[15:8];
      6'd36:         start_b = idat_len[7:0];
      [6'd37:6'd40]: start_b = IDAT_TYPE[2'(idx_r[1:0] - 2'd1)];
      6'd41:         start_b = ZLIB_CMF;
      6'd42:         start_b = ZLIB_FLG;
      default:       start_b = 8'h00;
    endcase
  end

  always_comb begin
    mode_nxt   = mode_r;
    idx_nxt    = idx_r;
    slot_nxt   = slot_r;
    col_nxt    = col_r;
    fill_nxt   = fill_r;
    left_nxt   = left_r;
    adl_nxt    = adl_r;
    adh_nxt    = adh_r;
    lw_nxt     = lw_r;
    lh_nxt     = lh_r;
    mul_go_nxt = 1'b0;
    cnt_nxt    = cnt_r;
    go         = 1'b0;
    pop        = 1'b0;
    byte_v     = 8'h00;
    crc_upd    = 1'b0;
    crc_fresh  = 1'b0;
    last_v     = 1'b0;
    eof_v      = 1'b0;
    if (mul_go_r) left_nxt = raw_prod[RAW_W-1:0];
    unique case (mode_r)
      M_ITEM: begin
        if (head_valid && can) begin
          go = 1'b1;
          if (head.is_start) begin
            byte_v     = PNG_SIG[0];
            lw_nxt     = head.width;
            lh_nxt     = head.height;
            mul_go_nxt = 1'b1;
            col_nxt    = '0;
            slot_nxt   = 2'd0;
            fill_nxt   = '0;
            adl_nxt    = 16'd1;
            adh_nxt    = 16'd0;
            mode_nxt   = M_START;
            idx_nxt    = 6'd1;
          end else if (fill_r == '0) begin
            byte_v   = final_blk ? 8'h01 : 8'h00;
            crc_upd  = 1'b1;
            slot_nxt = slot_eff;
            mode_nxt = M_BLK;
            idx_nxt  = 6'd1;
          end else begin
            byte_v   = raw_b;
            crc_upd  = 1'b1;
            adl_nxt  = new_l;
            adh_nxt  = new_h;
            fill_nxt = fill_r - 16'd1;
            left_nxt = left_r - RAW_W'(1);
            if (slot_eff == 2'd3) begin
              slot_nxt = 2'd0;
              col_nxt  = ({1'b0, col_r} + 14'd1 >= lw_r) ? '0 : col_r + COL_W'(1);
              if (left_r == RAW_W'(1)) begin
                mode_nxt = M_TAIL;
                idx_nxt  = '0;
              end else begin
                last_v = 1'b1;
                pop    = 1'b1;
              end
            end else begin
              slot_nxt = slot_eff + 2'd1;
            end
          end
        end
      end
      M_BLK: begin
        if (can) begin
          go      = 1'b1;
          crc_upd = 1'b1;
          case (idx_r[1:0])
            2'd1:    byte_v = len[7:0];
            2'd2:    byte_v = len[15:8];
            2'd3:    byte_v = nlen[7:0];
            default: byte_v = nlen[15:8];
          endcase
          if (idx_r == IDX_BLK_LAST) begin
            fill_nxt = len;
            mode_nxt = M_ITEM;
          end else begin
            idx_nxt = idx_r + 6'd1;
          end
        end
      end
      M_START: begin
        // The IDAT length waits for the block count divider.
        if (can && !(idx_r == IDX_IDAT_LEN && !div_done)) begin
          go        = 1'b1;
          byte_v    = start_b;
          crc_upd   = (idx_r >= IDX_IHDR_BODY && idx_r < IDX_IHDR_CRC)
                      || (idx_r >= IDX_IDAT_TYPE);
          crc_fresh = (idx_r == IDX_IHDR_BODY) || (idx_r == IDX_IDAT_TYPE);
          if (idx_r == IDX_START_LAST) begin
            last_v   = 1'b1;
            pop      = 1'b1;
            mode_nxt = M_ITEM;
          end else begin
            idx_nxt = idx_r + 6'd1;
          end
        end
      end
      M_TAIL: begin
        if (can) begin
          go = 1'b1;
          case (idx_r) inside
            6'd0:    byte_v = adler_word[31:24];
            6'd1:    byte_v = adler_word[23:16];
            6'd2:    byte_v = adler_word[15:8];
            6'd3:    byte_v = adler_word[7:0];
            6'd4:    byte_v = crc_out[31:24];
            6'd5:    byte_v = crc_out[23:16];
            6'd6:    byte_v = crc_out[15:8];
            6'd7:    byte_v = crc_out[7:0];
            default: byte_v = IEND_CHUNK[4'(idx_r - 6'd8)];
          endcase
          crc_upd = (idx_r < 6'd4);
          if (idx_r == IDX_TAIL_LAST) begin
            last_v   = 1'b1;
            eof_v    = 1'b1;
            pop      = 1'b1;
            col_nxt  = '0;
            mode_nxt = M_ITEM;
          end else begin
            idx_nxt = idx_r + 6'd1;
          end
        end
      end
      default: mode_nxt = M_ITEM;
    endcase
    if (go) cnt_nxt = pop ? '0 : (drop ? cnt_r : cnt_r + 6'd1);
  end

  always_comb begin
    crc_nxt = crc_r;
    if (go && crc_upd) crc_nxt = crc_byte(crc_fresh ? CRC_INIT : crc_r, byte_v);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= M_ITEM;
      idx_r       <= '0;
      slot_r      <= 2'd0;
      col_r       <= '0;
      fill_r      <= '0;
      left_r      <= '0;
      crc_r       <= CRC_INIT;
      adl_r       <= 16'd1;
      adh_r       <= 16'd0;
      cnt_r       <= '0;
      mul_go_r    <= 1'b0;
      div_go_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      mode_r   <= mode_nxt;
      idx_r    <= idx_nxt;
      slot_r   <= slot_nxt;
      col_r    <= col_nxt;
      fill_r   <= fill_nxt;
      left_r   <= left_nxt;
      crc_r    <= crc_nxt;
      adl_r    <= adl_nxt;
      adh_r    <= adh_nxt;
      cnt_r    <= cnt_nxt;
      mul_go_r <= mul_go_nxt;
      div_go_r <= mul_go_r;
      if (go && !drop) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    lw_r <= lw_nxt;
    lh_r <= lh_nxt;
    if (go && !drop) begin
      out_data_r.out_byte    <= byte_v;
      out_data_r.last_of_run <= last_v || (cnt_r == MAX_OUT - 6'd1);
      out_data_r.end_of_file <= eof_v;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTH
  a_blk_idx: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r == M_BLK |-> (idx_r >= 6'd1 && idx_r <= IDX_BLK_LAST))
    else $error("block header index out of range");
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    {12'b0, fill_r} <= BLK_LEN)
    else $error("block fill exceeds block length");
  a_eof_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.end_of_file |-> out_data_r.last_of_run)
    else $error("end of file without end of run");
  a_idat_wait: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r == M_START && idx_r == IDX_IDAT_LEN && go |-> div_done && !mul_go_r)
    else $error("IDAT length sent before divider finished");
`endif

endmodule
`default_nettype wire

// ===== rtl/png_stored_deflate_writer_core.sv =====
`default_nettype none
// PNG writer for 8-bit RGB images using stored (uncompressed) deflate blocks.
// A start word (func 0) latches the configured width and height, clamped to
// 1..MAX_DIMENSION, and produces the 43-byte file head: signature, IHDR with
// its CRC, the IDAT length, the IDAT type and the zlib header. Each pixel word
// produces its three sample bytes, plus a zero filter byte at the start of a
// row and a five-byte stored block header every BLOCK_LIMIT-5 raw bytes; the
// last pixel also produces the Adler-32, the IDAT CRC and IEND (20 bytes).
// Pixel words that arrive with no image open are taken and dropped.
// The output channel carries one byte per cycle while words are queued and
// the receiver is ready. The IDAT length comes from a short block-count
// multiply pipeline that finishes long before the length is due, so it
// never stalls. The front end classifies words and feeds a two-entry queue,
// so the input keeps being taken, until the queue fills, while the byte
// sequencer and its output register are busy or stalled. Width and height
// should be written only while idle.
module png_stored_deflate_writer_core import pngsd_pkg::*; #(
  parameter int BLOCK_LIMIT   = 32768,
  parameter int MAX_DIMENSION = 8192
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_we,
  input  wire logic             cfg_addr,
  input  wire logic [DIM_W-1:0] cfg_wdata,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire in_item_t         in_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output out_item_t             out_data
);

  logic q_full, q_push, q_pop, q_head_valid;
  cmd_t q_cmd, q_head;

  // Front end: configuration registers, size clamp and image open tracking.
  pngsd_front #(.MAX_DIMENSION(MAX_DIMENSION)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (q_cmd)
  );

  // Queue that decouples word intake from byte generation.
  pngsd_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_cmd   (q_cmd),
    .pop        (q_pop),
    .full       (q_full),
    .head_valid (q_head_valid),
    .head       (q_head)
  );

  // Back end: byte sequencer with running CRC-32 and Adler-32.
  pngsd_back #(.BLOCK_LIMIT(BLOCK_LIMIT)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (q_head_valid),
    .head       (q_head),
    .pop        (q_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule
`default_nettype wire

// ===== dv/tb.sv =====
`default_nettype none
module tb import pngsd_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int BLOCK_LIMIT   = 32768;
  localparam int MAX_DIMENSION = 8192;
  localparam int BLOCK_RAW     = BLOCK_LIMIT - 5;
  localparam int MAX_BYTES     = 43;
  localparam int WATCHDOG      = 20000;
  // Settling time after the last expected byte: covers the block-count divider.
  localparam int SETTLE        = 60;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic             cfg_addr;
  logic [DIM_W-1:0] cfg_wdata;
  logic             in_valid;
  logic             in_ready;
  in_item_t         in_data;
  logic             out_valid;
  logic             out_ready;
  out_item_t        out_data;

  png_stored_deflate_writer_core uut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // File-stream predictor. It mirrors the writer's state: the configured
  // size, the size latched at start, the row position, the fill of the
  // current stored block, the raw bytes still to come, and both checksums.
  // ---------------------------------------------------------------------
  logic [13:0] cfg_w, cfg_h;
  int unsigned img_w, img_h;
  bit          img_open;
  int unsigned col_pos, blk_fill, raw_left;
  logic [31:0] idat_crc;
  int unsigned adler_lo, adler_hi;

  out_item_t   item_bytes[$];    // bytes caused by the word being predicted
  out_item_t   file_bytes_due[$]; // bytes still expected on the output
  int          errors;
  int          idle_cycles;
  int          hold_off;          // cycles the receiver still refuses bytes

  function automatic logic [31:0] crc_next(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] x;
    x = c ^ {24'd0, b};
    for (int k = 0; k < 8; k++) x = x[0] ? (32'hEDB8_8320 ^ (x >> 1)) : (x >> 1);
    return x;
  endfunction

  function automatic int unsigned clamp_dim(input logic [13:0] v);
    if (v == 0) return 1;
    if (v > MAX_DIMENSION) return MAX_DIMENSION;
    return v;
  endfunction

  task automatic emit(input logic [7:0] b, input bit eof);
    out_item_t o;
    if (item_bytes.size() < MAX_BYTES) begin
      o.out_byte = b;
      o.last_of_run = 1'b0;
      o.end_of_file = eof;
      item_bytes = {item_bytes, o};
    end
  endtask

  task automatic emit_crc(input logic [7:0] b);
    idat_crc = crc_next(idat_crc, b);
    emit(b, 1'b0);
  endtask

  task automatic emit_be32(input logic [31:0] v, input bit with_crc);
    for (int i = 3; i >= 0; i--) begin
      if (with_crc) emit_crc(v[8*i +: 8]);
      else emit(v[8*i +: 8], 1'b0);
    end
  endtask

  // One raw zlib byte: opens a stored block when the previous one is full.
  task automatic raw_out(input logic [7:0] b);
    int unsigned len;
    logic [15:0] inv;
    if (raw_left == 0) return;
    if (blk_fill == 0) begin
      len = (raw_left < BLOCK_RAW) ? raw_left : BLOCK_RAW;
      inv = ~len[15:0];
      emit_crc((raw_left <= BLOCK_RAW) ? 8'h01 : 8'h00);
      emit_crc(len[7:0]);
      emit_crc(len[15:8]);
      emit_crc(inv[7:0]);
      emit_crc(inv[15:8]);
      blk_fill = len;
    end
    emit_crc(b);
    adler_lo = (adler_lo + b) % 65521;
    adler_hi = (adler_hi + adler_lo) % 65521;
    blk_fill--;
    raw_left--;
  endtask

  task automatic predict_start();
    logic [7:0]  sig[8] = '{8'h89, 8'h50, 8'h4E, 8'h47, 8'h0D, 8'h0A, 8'h1A, 8'h0A};
    logic [7:0]  hdr[17];
    logic [31:0] c;
    logic [31:0] wv, hv;
    int unsigned raw, blocks;
    img_w = clamp_dim(cfg_w);
    img_h = clamp_dim(cfg_h);
    wv = img_w;
    hv = img_h;
    foreach (sig[i]) emit(sig[i], 1'b0);
    emit_be32(32'd13, 1'b0);
    hdr = '{8'h49, 8'h48, 8'h44, 8'h52, wv[31:24], wv[23:16], wv[15:8], wv[7:0],
            hv[31:24], hv[23:16], hv[15:8], hv[7:0], 8'h08, 8'h02, 8'h00, 8'h00, 8'h00};
    c = 32'hFFFF_FFFF;
    foreach (hdr[i]) begin
      c = crc_next(c, hdr[i]);
      emit(hdr[i], 1'b0);
    end
    emit_be32(~c, 1'b0);
    raw = img_h * (img_w * 3 + 1);
    blocks = (raw + BLOCK_RAW - 1) / BLOCK_RAW;
    emit_be32(2 + raw + 5 * blocks + 4, 1'b0);
    idat_crc = 32'hFFFF_FFFF;
    emit_crc(8'h49); emit_crc(8'h44); emit_crc(8'h41); emit_crc(8'h54);
    emit_crc(8'h78); emit_crc(8'hDA);
    img_open = 1'b1;
    col_pos = 0;
    blk_fill = 0;
    raw_left = raw;
    adler_lo = 1;
    adler_hi = 0;
  endtask

  task automatic predict_pixel(input in_item_t w);
    logic [7:0] iend[12] = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h49, 8'h45, 8'h4E, 8'h44,
                             8'hAE, 8'h42, 8'h60, 8'h82};
    logic [31:0] adler;
    if (!img_open) return;
    if (col_pos == 0) raw_out(8'h00);
    raw_out(w.red);
    raw_out(w.green);
    raw_out(w.blue);
    col_pos++;
    if (col_pos >= img_w) col_pos = 0;
    if (raw_left == 0) begin
      adler = {adler_hi[15:0], adler_lo[15:0]};
      emit_be32(adler, 1'b1);
      emit_be32(~idat_crc, 1'b0);
      foreach (iend[i]) emit(iend[i], i == 11);
      img_open = 1'b0;
      col_pos = 0;
    end
  endtask

  task automatic predict_word(input in_item_t w);
    item_bytes.delete();
    if (w.func == FUNC_START) predict_start();
    else predict_pixel(w);
    if (item_bytes.size() > 0) item_bytes[item_bytes.size()-1].last_of_run = 1'b1;
    file_bytes_due = {file_bytes_due, item_bytes};
  endtask

  // ---------------------------------------------------------------------
  // Mismatch reporting and the output checker.
  // ---------------------------------------------------------------------
  task automatic report(input string msg);
    $display("ERROR at %0t: %s", $realtime, msg);
    errors++;
  endtask

  // Receiver: random stalls, a few long ones, plus the forced hold-off.
  initial begin
    int stall;
    out_ready = 1'b0;
    stall = 0;
    forever begin
      @(posedge clk);
      if (hold_off > 0) begin
        hold_off--;
        out_ready <= 1'b0;
      end else if (stall > 0) begin
        stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 99) < 15)
          stall = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
      end
    end
  end

  // Every accepted byte is compared with the oldest expected one.
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (file_bytes_due.size() == 0) begin
        report($sformatf("unexpected byte %02h", out_data.out_byte));
      end else begin
        want = file_bytes_due.pop_front();
        if (out_data.out_byte !== want.out_byte)
          report($sformatf("byte %02h, expected %02h", out_data.out_byte, want.out_byte));
        if (out_data.last_of_run !== want.last_of_run)
          report($sformatf("last_of_run %b, expected %b on byte %02h",
                           out_data.last_of_run, want.last_of_run, want.out_byte));
        if (out_data.end_of_file !== want.end_of_file)
          report($sformatf("end_of_file %b, expected %b on byte %02h",
                           out_data.end_of_file, want.end_of_file, want.out_byte));
      end
    end
  end

  // Watchdog: too long with no word moving on either channel ends the run.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------
  // Offers one word and waits until it is taken. With no gap the valid stays
  // high so that the caller can present the next word at once.
  task automatic send_word(input in_item_t w, input bit allow_gap = 1'b1);
    int gap;
    in_valid <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_word(w);
    gap = 0;
    if (allow_gap && $urandom_range(0, 99) < 35)
      gap = ($urandom_range(0, 14) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_start();
    in_item_t w;
    w = '0;
    w.func = FUNC_START;
    w.red = 8'($urandom);
    w.green = 8'($urandom);
    w.blue = 8'($urandom);
    send_word(w);
  endtask

  task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    in_item_t w;
    w.func = FUNC_PIXEL;
    w.red = r;
    w.green = g;
    w.blue = b;
    send_word(w);
  endtask

  task automatic send_random_pixels(input int n);
    repeat (n) send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  // Stops offering, lets every expected byte arrive and the block settle.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (file_bytes_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic addr, input logic [13:0] value);
    cfg_we <= 1'b1;
    cfg_addr <= addr;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (addr == CFG_WIDTH) cfg_w = value;
    else cfg_h = value;
  endtask

  task automatic set_size(input logic [13:0] w, input logic [13:0] h);
    drain();
    write_reg(CFG_WIDTH, w);
    write_reg(CFG_HEIGHT, h);
  endtask

  // One complete image with random content.
  task automatic full_image(input logic [13:0] w, input logic [13:0] h);
    set_size(w, h);
    send_start();
    send_random_pixels(clamp_dim(w) * clamp_dim(h));
  endtask

  // ---------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------
  // The reset size is 1 x 1: a start and a single pixel form a whole file.
  task automatic test_reset_size();
    send_start();
    send_pixel(8'h00, 8'hFF, 8'hA5);
  endtask

  // Pixels with no image open are dropped and produce nothing.
  task automatic test_idle_pixels();
    drain();
    send_pixel(8'hFF, 8'hFF, 8'hFF);
    send_pixel(8'h00, 8'h00, 8'h00);
  endtask

  // Zero and oversized dimensions are clamped; the huge image opens a
  // non-final stored block, then a new start drops it mid-image.
  task automatic test_size_clamp();
    set_size(14'd0, 14'd0);
    send_start();
    send_pixel(8'hFF, 8'h00, 8'hFF);
    set_size(14'h3FFF, 14'd8192);
    send_start();
    send_pixel(8'h55, 8'hAA, 8'h00);
    send_pixel(8'hFF, 8'hFF, 8'hFF);
    send_pixel(8'h01, 8'h80, 8'h7F);
    send_start();
    send_random_pixels(2);
    // A register write while an image is open must not affect that image.
    drain();
    write_reg(CFG_WIDTH, 14'd8193);
    send_random_pixels(1);
    set_size(14'd2, 14'd1);
    send_start();
    send_pixel(8'h00, 8'h00, 8'h00);
    send_pixel(8'hFF, 8'hFF, 8'hFF);
  endtask

  // A restart in the middle of a small image, then that image to the end.
  task automatic test_restart();
    set_size(14'd3, 14'd2);
    send_start();
    send_random_pixels(4);
    send_start();
    send_random_pixels(6);
  endtask

  // The receiver holds off for a long stretch while pixels keep coming,
  // so the block backs up and stalls its input.
  task automatic test_backpressure();
    set_size(14'd5, 14'd4);
    hold_off = 400;
    send_start();
    for (int i = 0; i < 20; i++)
      send_word('{FUNC_PIXEL, 8'($urandom), 8'($urandom), 8'($urandom)}, 1'b0);
  endtask

  // Mostly well-formed images of random small size, with some noise:
  // stray pixels while idle and restarts that cut an image short.
  task automatic test_random_images();
    int sent;
    int w, h, n;
    sent = 0;
    while (sent < 300) begin
      w = $urandom_range(1, 6);
      h = $urandom_range(1, 4);
      case ($urandom_range(0, 9))
        0: begin
          drain();
          n = $urandom_range(1, 3);
          send_random_pixels(n);
          sent += n;
        end
        1: begin
          set_size(14'(w), 14'(h));
          send_start();
          n = $urandom_range(0, w * h - 1);
          send_random_pixels(n);
          send_start();
          send_random_pixels(w * h);
          sent += n + w * h + 2;
        end
        default: begin
          full_image(14'(w), 14'(h));
          sent += w * h + 1;
        end
      endcase
    end
  endtask

  initial begin
    errors = 0;
    idle_cycles = 0;
    hold_off = 0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_addr = CFG_WIDTH;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_w = 14'd1;
    cfg_h = 14'd1;
    img_w = 1;
    img_h = 1;
    img_open = 1'b0;
    col_pos = 0;
    blk_fill = 0;
    raw_left = 0;
    idat_crc = 32'hFFFF_FFFF;
    adler_lo = 1;
    adler_hi = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_size();
    test_idle_pixels();
    test_size_clamp();
    test_restart();
    test_backpressure();
    test_random_images();
    drain();

    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
`default_nettype wire

// ===== sim.f =====
rtl/pngsd_pkg.sv
rtl/pngsd_front.sv
rtl/pngsd_fifo.sv
rtl/pngsd_div.sv
rtl/pngsd_back.sv
rtl/png_stored_deflate_writer_core.sv
dv/tb.sv
